// ----- sv/assert_macros.svh -----
// Assertion macros shared by the servo slew stepper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds whenever the antecedent holds, same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ssps_pkg.sv -----
// Shared types and constants of the servo slew stepper.
`default_nettype none

package ssps_pkg;

    // command codes carried in tuser
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_SET      = 3'd1;
    localparam logic [2:0] OP_MOVE_ABS = 3'd2;
    localparam logic [2:0] OP_MOVE_REL = 3'd3;
    localparam logic [2:0] OP_SPEED    = 3'd4;
    localparam logic [2:0] OP_STOP     = 3'd5;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_STEP_INTERVAL = 2'd0;
    localparam logic [1:0] REG_LIMIT_HIGH    = 2'd1;
    localparam logic [1:0] REG_LIMIT_LOW     = 2'd2;

    localparam logic [15:0]       RESET_INTERVAL   = 16'd5;
    localparam logic signed [9:0] RESET_LIMIT_HIGH = 10'sd180;
    localparam logic signed [9:0] RESET_LIMIT_LOW  = -10'sd180;

    // speed mode: interval = 500 / |deg per s|
    localparam int          QW           = 9;
    localparam logic [8:0]  DIV_DIVIDEND = 9'd500;
    localparam logic [16:0] SPEED_MAX    = 17'd500;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic exec;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_is_speed;
        logic div_busy;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/ssps_div.sv -----
// Restoring divider for the speed-mode step interval, one quotient bit per cycle.
`default_nettype none

module ssps_div
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [ssps_pkg::QW-1:0]  divisor,
    output logic                          busy,
    output logic                          done,
    output logic [ssps_pkg::QW-1:0]       quotient
);
    import ssps_pkg::*;

    localparam int CW = $clog2(QW);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg,  cnt_next;
    logic [QW-1:0] quo_reg,  quo_next;
    logic [QW-1:0] rem_reg,  rem_next;
    logic [QW-1:0] dvs_reg,  dvs_next;
    logic [QW:0]   shifted;
    logic [QW:0]   trial;

    assign shifted = {rem_reg, quo_reg[QW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = DIV_DIVIDEND;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // keep the remainder when the trial subtract goes negative
            if (!trial[QW])
            begin
                rem_next = trial[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[QW-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(QW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- sv/ssps_dp.sv -----
// Datapath: position state, step timer, command execution and result register.
`default_nettype none

module ssps_dp #(
    parameter int POS_WIDTH   = 11,
    parameter int TIMER_WIDTH = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ssps_pkg::cmd_t     cmd,
    output ssps_pkg::status_t       status,
    input  wire logic [2:0]         in_op,
    input  wire logic [31:0]        in_data,
    input  wire logic [15:0]        step_interval_ms,
    input  wire logic signed [9:0]  limit_high,
    input  wire logic signed [9:0]  limit_low,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [31:0]             out_data
);
    import ssps_pkg::*;

    localparam int AIW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;
    localparam int EW  = TIMER_WIDTH + 1;
    localparam int CW  = AIW + 1;
    localparam int WW  = ((POS_WIDTH > 11) ? POS_WIDTH : 11) + 1;

    logic [2:0]                  op_reg;
    logic signed [10:0]          arg_reg;
    logic signed [15:0]          spd_reg;

    logic signed [POS_WIDTH-1:0] cur_reg;
    logic signed [POS_WIDTH-1:0] goal_reg;
    logic [AIW-1:0]              ival_reg;
    logic [EW-1:0]               elapsed_reg;
    logic                        posmode_reg;
    logic                        dirup_reg;
    logic                        wrote_reg;
    logic                        out_valid_reg;
    logic [31:0]                 out_data_reg;

    logic signed [WW-1:0]        cur_w, goal_w, arg_w, lh_w, ll_w;
    logic signed [WW-1:0]        np, mv_raw, clamp_hi, clamp_lo;
    logic signed [POS_WIDTH-1:0] goal_new;
    logic                        moving, up, np_ok, set_ok, step_due;
    logic [EW-1:0]               el_inc;
    logic [CW-1:0]               el_cmp, ival_p1;
    logic signed [16:0]          spd_x;
    logic [16:0]                 spd_abs;
    logic                        spd_none;
    logic                        div_busy, div_done;
    logic [QW-1:0]               quo;
    logic [QW+TIMER_WIDTH-1:0]   quo_wide;
    logic [AIW-1:0]              ival_spd;

    assign cur_w  = {{(WW-POS_WIDTH){cur_reg[POS_WIDTH-1]}}, cur_reg};
    assign goal_w = {{(WW-POS_WIDTH){goal_reg[POS_WIDTH-1]}}, goal_reg};
    assign arg_w  = {{(WW-11){arg_reg[10]}}, arg_reg};
    assign lh_w   = {{(WW-10){limit_high[9]}}, limit_high};
    assign ll_w   = {{(WW-10){limit_low[9]}}, limit_low};

    assign moving = posmode_reg ? (cur_reg != goal_reg) : (ival_reg != '0);

    // tick: saturating timer, half-degree step once interval+1 ticks have passed
    assign el_inc   = (&elapsed_reg) ? elapsed_reg : elapsed_reg + EW'(1);
    assign el_cmp   = CW'(el_inc);
    assign ival_p1  = CW'(ival_reg) + CW'(1);
    assign step_due = (ival_reg != '0) && moving && (el_cmp >= ival_p1);
    assign up       = posmode_reg ? (goal_w > cur_w) : dirup_reg;
    assign np       = up ? cur_w + WW'(1) : cur_w - WW'(1);
    assign np_ok    = !(np > lh_w || np < ll_w);
    assign set_ok   = !(arg_w > lh_w || arg_w < ll_w);

    // moves: clamp to the high limit first, then the low one
    assign mv_raw   = (op_reg == OP_MOVE_REL) ? arg_w + cur_w : arg_w;
    assign clamp_hi = (mv_raw > lh_w) ? lh_w : mv_raw;
    assign clamp_lo = (clamp_hi < ll_w) ? ll_w : clamp_hi;
    assign goal_new = clamp_lo[POS_WIDTH-1:0];

    assign spd_x    = {spd_reg[15], spd_reg};
    assign spd_abs  = spd_x[16] ? 17'(-spd_x) : 17'(spd_x);
    assign spd_none = (spd_abs == '0) || (spd_abs > SPEED_MAX);
    assign quo_wide = {{TIMER_WIDTH{1'b0}}, quo};
    assign ival_spd = AIW'(quo_wide[TIMER_WIDTH-1:0]);

    ssps_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (spd_abs[QW-1:0]),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_op;
            arg_reg <= in_data[10:0];
            spd_reg <= in_data[26:11];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg     <= '0;
            goal_reg    <= '0;
            ival_reg    <= AIW'(RESET_INTERVAL);
            elapsed_reg <= '0;
            posmode_reg <= 1'b1;
            dirup_reg   <= 1'b0;
            wrote_reg   <= 1'b0;
        end
        else if (cmd.exec)
        begin
            wrote_reg <= ((op_reg == OP_TICK) && step_due && np_ok) ||
                         ((op_reg == OP_SET) && set_ok);
            unique case (op_reg)
                OP_TICK:
                begin
                    elapsed_reg <= step_due ? '0 : el_inc;
                    if (step_due && np_ok)
                    begin
                        cur_reg <= np[POS_WIDTH-1:0];
                    end
                end
                OP_SET:
                begin
                    if (set_ok)
                    begin
                        cur_reg <= arg_w[POS_WIDTH-1:0];
                    end
                end
                OP_MOVE_ABS, OP_MOVE_REL:
                begin
                    posmode_reg <= 1'b1;
                    ival_reg    <= AIW'(step_interval_ms);
                    if (step_interval_ms != '0)
                    begin
                        elapsed_reg <= '0;
                        goal_reg    <= goal_new;
                        dirup_reg   <= goal_new > cur_reg;
                    end
                end
                OP_SPEED:
                begin
                    posmode_reg <= 1'b0;
                    dirup_reg   <= !spd_reg[15] && (spd_reg != '0);
                    ival_reg    <= spd_none ? '0 : ival_spd;
                    elapsed_reg <= '0;
                end
                OP_STOP:
                begin
                    goal_reg    <= cur_reg;
                    posmode_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register parts the output handshake from the execution
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {7'b0, wrote_reg, (cur_reg == '0), !posmode_reg, dirup_reg,
                             moving, goal_w[9:0], cur_w[9:0]};
        end
    end

    assign status.in_is_speed = (in_op == OP_SPEED);
    assign status.div_busy    = div_busy;
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/ssps_ctrl.sv -----
// Controller state machine: sequences accept, divide, execute and result load.
`default_nettype none
`include "assert_macros.svh"

module ssps_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ssps_pkg::status_t  status,
    output ssps_pkg::cmd_t          cmd
);
    import ssps_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = status.in_is_speed ? S_START : S_EXEC;
                end
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the result register is free
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign cmd.capture   = (state_reg == S_IDLE) && in_valid;
    assign cmd.div_start = (state_reg == S_START);
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.emit      = (state_reg == S_EMIT) && status.out_free;

    `ASSERT_NEXT(a_speed_starts_div, clk, rst_n, cmd.capture && status.in_is_speed,
                 cmd.div_start, "speed command did not start the divider")
    `ASSERT_IMPL(a_exec_after_div, clk, rst_n, cmd.exec, !status.div_busy,
                 "command executed while the divider is busy")
    `ASSERT_IMPL(a_done_in_div, clk, rst_n, status.div_done, state_reg == S_DIV,
                 "divider finished outside the divide state")

endmodule

`default_nettype wire

// ----- sv/servo_slew_position_stepper.sv -----
// Top level: configuration registers, controller and datapath of the servo slew stepper.
`default_nettype none

// Servo slew stepper in half-degree units. Each s-side transfer is a 1 ms tick or a
// command (tuser: tick, set, move absolute, move relative, speed, stop) and yields
// exactly one m-side transfer with position, target and status flags after the item
// is applied. An item goes through execute and emit into the free result register; a
// speed command first waits on the nine-step restoring divider forming 500/|speed|.
// A finished result waits in its own register, so the next item is accepted while it
// is still pending. Write registers over APB only while the block is idle.
module servo_slew_position_stepper #(
    parameter int POS_WIDTH   = 11,
    parameter int TIMER_WIDTH = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // angle_arg[10:0], speed_dps[26:11], zero fill
    input  wire logic [2:0]  s_tuser,   // op[2:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // position[9:0], target[19:10], moving[20],
                                        // direction_up[21], speed_mode[22], at_home[23],
                                        // servo_write[24], zero fill
);
    import ssps_pkg::*;

    logic [15:0]       step_interval_reg;
    logic signed [9:0] limit_high_reg;
    logic signed [9:0] limit_low_reg;
    logic              wr_en;
    cmd_t              cmd;
    status_t           status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_interval_reg <= RESET_INTERVAL;
            limit_high_reg    <= RESET_LIMIT_HIGH;
            limit_low_reg     <= RESET_LIMIT_LOW;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_STEP_INTERVAL: step_interval_reg <= pwdata[15:0];
                REG_LIMIT_HIGH:    limit_high_reg    <= pwdata[9:0];
                REG_LIMIT_LOW:     limit_low_reg     <= pwdata[9:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_STEP_INTERVAL: prdata = {16'b0, step_interval_reg};
            REG_LIMIT_HIGH:    prdata = {{22{limit_high_reg[9]}}, limit_high_reg};
            REG_LIMIT_LOW:     prdata = {{22{limit_low_reg[9]}}, limit_low_reg};
            default:           prdata = '0;
        endcase
    end

    ssps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ssps_dp #(
        .POS_WIDTH   (POS_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .in_op            (s_tuser),
        .in_data          (s_tdata),
        .step_interval_ms (step_interval_reg),
        .limit_high       (limit_high_reg),
        .limit_low        (limit_low_reg),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_data         (m_tdata)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the servo slew stepper: stream stimulus, APB setup, result checks.
`timescale 1ns / 1ps

module tb;
    import ssps_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_TICKS = 24;
    localparam int unsigned ELAPSED_MAX  = 17'h1FFFF;

    typedef struct packed {
        logic signed [9:0] position;
        logic signed [9:0] target;
        logic              moving;
        logic              direction_up;
        logic              speed_mode;
        logic              at_home;
        logic              servo_write;
    } servo_status_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;  // angle_arg[10:0], speed_dps[26:11], zero fill
    logic [2:0]  s_tuser  = '0;  // op[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;        // position[9:0], target[19:10], moving[20],
                                 // direction_up[21], speed_mode[22], at_home[23],
                                 // servo_write[24], zero fill

    servo_slew_position_stepper i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // programmed registers as seen by the predictor
    int unsigned cfg_interval;
    int          lim_hi;
    int          lim_lo;

    // predicted servo state
    int          pos;
    int          goal;
    int unsigned run_interval;
    int unsigned elapsed;
    bit          pos_mode;
    bit          dir_up;

    servo_status_t status_q[$];

    int tx_idle_pct;
    int rx_idle_pct;
    int cycle_count;
    int results_seen;
    int mismatch_count;
    int error_count;
    int items_sent;
    int steps_seen;
    int speed_cmds;
    int reg_writes;

    function automatic int rand_span(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic bit within_limits(int p);
        return p <= lim_hi && p >= lim_lo;
    endfunction

    function automatic bit slewing();
        if (!pos_mode)
            return run_interval != 0;
        return pos != goal;
    endfunction

    function automatic void arm_move(int g);
        pos_mode     = 1'b1;
        run_interval = cfg_interval;
        // zero interval: mode and interval change, goal and timer stay
        if (run_interval == 0)
            return;
        elapsed = 0;
        if (g > lim_hi)
            g = lim_hi;
        if (g < lim_lo)
            g = lim_lo;
        goal   = g;
        dir_up = goal > pos;
    endfunction

    function automatic servo_status_t predict_step(logic [2:0] op, int ang, int spd);
        servo_status_t res;
        bit            wrote;
        int            next_pos;
        int            mag;
        wrote = 1'b0;
        case (op)
            OP_TICK:
            begin
                if (elapsed < ELAPSED_MAX)
                    elapsed++;
                if (run_interval != 0 && slewing() && elapsed >= run_interval + 1)
                begin
                    if (pos_mode)
                        next_pos = (goal > pos) ? pos + 1 : pos - 1;
                    else
                        next_pos = dir_up ? pos + 1 : pos - 1;
                    // out of range: hold position but rearm the timer
                    if (within_limits(next_pos))
                    begin
                        pos   = next_pos;
                        wrote = 1'b1;
                    end
                    elapsed = 0;
                end
            end
            OP_SET:
            begin
                if (within_limits(ang))
                begin
                    pos   = ang;
                    wrote = 1'b1;
                end
            end
            OP_MOVE_ABS: arm_move(ang);
            OP_MOVE_REL: arm_move(ang + pos);
            OP_SPEED:
            begin
                mag          = (spd < 0) ? -spd : spd;
                pos_mode     = 1'b0;
                dir_up       = spd > 0;
                run_interval = (mag != 0) ? ((500 / mag) & 16'hFFFF) : 0;
                elapsed      = 0;
            end
            OP_STOP:
            begin
                goal     = pos;
                pos_mode = 1'b1;
            end
            default: ;
        endcase
        res.position     = pos[9:0];
        res.target       = goal[9:0];
        res.moving       = slewing();
        res.direction_up = dir_up;
        res.speed_mode   = !pos_mode;
        res.at_home      = (pos == 0);
        res.servo_write  = wrote;
        return res;
    endfunction

    // result checker and receiver back-pressure
    always @(posedge clk)
    begin
        servo_status_t got;
        servo_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[9:0], m_tdata[19:10], m_tdata[20], m_tdata[21],
                   m_tdata[22], m_tdata[23], m_tdata[24]};
            if (status_q.size() == 0)
            begin
                error_count++;
                if (error_count + mismatch_count <= 10)
                    $display("unexpected result transfer, m_tdata %h", m_tdata);
            end
            else
            begin
                want = status_q.pop_front();
                if (got != want)
                begin
                    mismatch_count++;
                    if (error_count + mismatch_count <= 10)
                    begin
                        $display("result %0d: expected pos %0d tgt %0d mv %b up %b spd %b home %b wr %b",
                                 results_seen, want.position, want.target, want.moving,
                                 want.direction_up, want.speed_mode, want.at_home,
                                 want.servo_write);
                        $display("result %0d: got pos %0d tgt %0d mv %b up %b spd %b home %b wr %b",
                                 results_seen, got.position, got.target, got.moving,
                                 got.direction_up, got.speed_mode, got.at_home,
                                 got.servo_write);
                    end
                end
            end
            results_seen++;
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** servo_slew_position_stepper: FAILED **");
        $finish;
    end

    task automatic send_item(input logic [2:0] op, input logic signed [10:0] ang,
                             input logic signed [15:0] spd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, spd, ang};
        do
            @(posedge clk);
        while (!s_tready);
        status_q.push_back(predict_step(op, ang, spd));
        items_sent++;
        if (status_q[$].servo_write)
            steps_seen++;
        if (op == OP_SPEED)
            speed_cmds++;
    endtask

    // drop valid, drain every pending result, then let the divider settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // setup cycle then access cycle; the caller closes the last transfer
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic apply_settings(input int unsigned iv, input int hi, input int lo);
        wait_idle();
        write_reg(REG_STEP_INTERVAL, iv);
        write_reg(REG_LIMIT_HIGH, hi);
        write_reg(REG_LIMIT_LOW, lo);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_interval = iv;
        lim_hi       = hi;
        lim_lo       = lo;
    endtask

    // mostly ticks so that moves and speed runs make progress
    task automatic send_random_item();
        logic [2:0]         op;
        logic signed [10:0] ang;
        logic signed [15:0] spd;
        int                 pick;
        int                 span_lo;
        int                 span_hi;
        int                 mag;
        pick    = $urandom_range(99);
        ang     = 11'($urandom);
        spd     = 16'($urandom);
        span_lo = ((lim_lo < lim_hi) ? lim_lo : lim_hi) - 5;
        span_hi = ((lim_lo < lim_hi) ? lim_hi : lim_lo) + 5;
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 63)
            op = OP_SET;
        else if (pick < 72)
            op = OP_MOVE_ABS;
        else if (pick < 82)
            op = OP_MOVE_REL;
        else if (pick < 90)
            op = OP_SPEED;
        else if (pick < 96)
            op = OP_STOP;
        else
            op = $urandom_range(1) ? OP_SPARE_6 : OP_SPARE_7;
        if (op == OP_SET || op == OP_MOVE_ABS)
            ang = ($urandom_range(99) < 70) ? 11'(rand_span(span_lo, span_hi))
                                            : 11'(rand_span(-720, 720));
        else if (op == OP_MOVE_REL)
            ang = ($urandom_range(99) < 75) ? 11'(rand_span(-20, 20))
                                            : 11'(rand_span(-720, 720));
        else if (op == OP_SPEED)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                mag = 0;
            else if (pick < 70)
                mag = rand_span(100, 500);
            else if (pick < 85)
                mag = rand_span(1, 99);
            else
                mag = -1;
            if (mag >= 0)
                spd = $urandom_range(1) ? 16'(mag) : 16'(-mag);
        end
        send_item(op, ang, spd);
    endtask

    task automatic test_directed();
        send_item(OP_TICK, 0, 0);
        send_item(OP_SET, 100, 0);
        send_item(OP_SET, 181, 0);
        send_item(OP_SET, -720, -32768);
        send_item(OP_SET, 720, 32767);
        send_item(OP_SET, 180, 0);
        send_item(OP_SET, -180, 0);
        send_item(OP_SET, 0, 0);
        // clamped to the upper limit; the sixth tick takes a step
        send_item(OP_MOVE_ABS, 720, 0);
        repeat (6) send_item(OP_TICK, 0, 0);
        send_item(OP_MOVE_REL, -720, 0);
        send_item(OP_SPEED, 0, 0);
        send_item(OP_SPEED, 0, -32768);
        send_item(OP_SPEED, 0, 32767);
        send_item(OP_SPEED, 0, 500);
        send_item(OP_SPEED, 0, -1);
        send_item(OP_TICK, -1, -1);
        send_item(OP_STOP, 0, 0);
        send_item(OP_SPARE_6, -1, -1);
        send_item(OP_SPARE_7, 0, 0);
    endtask

    // zero interval, slowest interval, inverted and collapsed limits, widest limits
    task automatic test_setting_sweep();
        int unsigned ivs[5] = '{0, 65535, 1, 2, 1};
        int          his[5] = '{360, 180, -40, 0, 360};
        int          los[5] = '{-360, -180, 40, 0, -360};
        for (int k = 0; k < 5; k++)
        begin
            apply_settings(ivs[k], his[k], los[k]);
            repeat (30) send_random_item();
        end
    endtask

    task automatic test_random_traffic(input int count);
        int          pick;
        int unsigned iv;
        int          hi;
        int          lo;
        for (int k = 0; k < count; k++)
        begin
            if (k % 60 == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                    iv = 0;
                else if (pick < 85)
                    iv = $urandom_range(3, 1);
                else
                    iv = $urandom_range(40, 4);
                hi = $urandom_range(360);
                lo = -int'($urandom_range(360));
                if ($urandom_range(9) == 0)
                    apply_settings(iv, lo, hi);
                else
                    apply_settings(iv, hi, lo);
            end
            send_random_item();
        end
    endtask

    initial
    begin
        cfg_interval = RESET_INTERVAL;
        lim_hi       = RESET_LIMIT_HIGH;
        lim_lo       = RESET_LIMIT_LOW;
        pos          = 0;
        goal         = 0;
        run_interval = RESET_INTERVAL;
        elapsed      = 0;
        pos_mode     = 1'b1;
        dir_up       = 1'b0;
        tx_idle_pct  = 27;
        rx_idle_pct  = 59;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_setting_sweep();
        test_random_traffic(190);
        tx_idle_pct = 59;
        rx_idle_pct = 27;
        test_random_traffic(190);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_traffic(190);

        wait_idle();
        $display("covered %0d items (%0d speed commands) over %0d register writes",
                 items_sent, speed_cmds, reg_writes);
        $display("checked %0d results, %0d with a servo step; %0d mismatches, %0d stray",
                 results_seen, steps_seen, mismatch_count, error_count);
        if (mismatch_count == 0 && error_count == 0)
            $display("** servo_slew_position_stepper: PASSED **");
        else
            $display("** servo_slew_position_stepper: FAILED **");
        $finish;
    end

endmodule
